// File: rtl/dihs_pkg.sv
// ----------------------------------------------------------------------------
// dihs_pkg
// Shared types, codes and helper functions for the driver init/health
// supervisor.
// ----------------------------------------------------------------------------
package dihs_pkg;

  // Status codes
  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_RETRYING   = 4'd1,
    ST_RETRY_COMM = 4'd2,
    ST_RETRY_ENN  = 4'd3,
    ST_RETRY_MODE = 4'd4,
    ST_SD_OK      = 4'd5,
    ST_POS_OK     = 4'd6,
    ST_COMM_ERR   = 4'd7,
    ST_ENN_ERR    = 4'd8,
    ST_MODE_ERR   = 4'd9,
    ST_TIMEOUT    = 4'd10,
    ST_ESTOP      = 4'd11
  } status_t;

  // Command codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_ESTOP = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REINIT_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT  = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] RST_RETRY_DELAY   = 16'd10;
  localparam logic [15:0] RST_HEARTBEAT     = 16'd100;
  localparam logic [15:0] RST_REINIT_PERIOD = 16'd1000;
  localparam logic [15:0] RST_LOOP_TIMEOUT  = 16'd50;
  localparam logic [15:0] RST_INIT_TIMEOUT  = 16'd200;

  // Version field value meaning the bus is floating
  localparam logic [7:0] NO_COMM_MARK = 8'hFF;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [7:0]  ioin_version;
    logic        enn_pin;
    logic        mode_pin;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status_code;
    logic [3:0]  prior_status;
    logic        pins_sampled;
    logic        write_settings;
    logic        reset_driver;
    logic [15:0] success_count;
  } out_item_t;

  typedef struct packed {
    logic        ramp_mode;
    logic [15:0] retry_delay;
    logic [15:0] heartbeat_interval;
    logic [15:0] reinit_period;
    logic [15:0] loop_timeout;
    logic [15:0] init_timeout;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    status_t     prior;
    logic [31:0] init_start;
    logic [31:0] last_check;
    logic [31:0] last_beat;
    logic [31:0] last_reinit;
    logic [15:0] success;
  } state_t;

  function automatic logic is_ok(status_t s);
    return (s == ST_SD_OK) || (s == ST_POS_OK);
  endfunction

  function automatic logic is_err(status_t s);
    return s inside {[ST_COMM_ERR:ST_TIMEOUT]};
  endfunction

  function automatic logic is_done(status_t s);
    return is_ok(s) || is_err(s);
  endfunction

  // Init in progress: retrying with or without a known fault
  function automatic logic is_busy(status_t s);
    return s inside {[ST_RETRYING:ST_RETRY_MODE]};
  endfunction

  // Map the sampled pins to a status code
  function automatic status_t judge_pins(in_item_t it, logic ramp_mode, logic during_init);
    status_t s;
    if ((it.ioin_version == NO_COMM_MARK) || (it.ioin_version == 8'd0)) begin
      s = during_init ? ST_RETRY_COMM : ST_COMM_ERR;
    end else if (it.enn_pin) begin
      s = during_init ? ST_RETRY_ENN : ST_ENN_ERR;
    end else if (it.mode_pin != ramp_mode) begin
      s = ramp_mode ? ST_POS_OK : ST_SD_OK;
    end else begin
      s = during_init ? ST_RETRY_MODE : ST_MODE_ERR;
    end
    return s;
  endfunction

  // Init window ran out: a known retry fault hardens, otherwise timeout
  function automatic status_t expire(status_t s);
    status_t r;
    case (s)
      ST_RETRY_COMM: r = ST_COMM_ERR;
      ST_RETRY_ENN:  r = ST_ENN_ERR;
      ST_RETRY_MODE: r = ST_MODE_ERR;
      default:       r = ST_TIMEOUT;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/dihs_cfg.sv
// ----------------------------------------------------------------------------
// dihs_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module dihs_cfg
  import dihs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_mode          <= 1'b0;
      cfg_r.retry_delay        <= RST_RETRY_DELAY;
      cfg_r.heartbeat_interval <= RST_HEARTBEAT;
      cfg_r.reinit_period      <= RST_REINIT_PERIOD;
      cfg_r.loop_timeout       <= RST_LOOP_TIMEOUT;
      cfg_r.init_timeout       <= RST_INIT_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RAMP_MODE:     cfg_r.ramp_mode          <= cfg_wdata[0];
        CFG_RETRY_DELAY:   cfg_r.retry_delay        <= cfg_wdata;
        CFG_HEARTBEAT:     cfg_r.heartbeat_interval <= cfg_wdata;
        CFG_REINIT_PERIOD: cfg_r.reinit_period      <= cfg_wdata;
        CFG_LOOP_TIMEOUT:  cfg_r.loop_timeout       <= cfg_wdata;
        CFG_INIT_TIMEOUT:  cfg_r.init_timeout       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/dihs_step.sv
// ----------------------------------------------------------------------------
// dihs_step
// Next-state and result logic for one command item.
// ----------------------------------------------------------------------------
module dihs_step
  import dihs_pkg::*;
(
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  state_t    cur,
  output state_t    nxt,
  output out_item_t res
);

  logic [31:0] t;
  logic [31:0] d_chk, d_beat, d_init, d_reinit;
  logic        due_retry, due_beat, due_reinit, expired;
  status_t     judge_init, judge_hb, st;
  logic        sampled, wr_set, rst_drv;

  assign t          = item.now_ms;
  assign d_chk      = t - cur.last_check;
  assign d_beat     = t - cur.last_beat;
  assign d_init     = t - cur.init_start;
  assign d_reinit   = t - cur.last_reinit;
  assign due_retry  = d_chk >= {16'd0, cfg.retry_delay};
  assign due_beat   = d_beat >= {16'd0, cfg.heartbeat_interval};
  assign due_reinit = d_reinit >= {16'd0, cfg.reinit_period};
  assign expired    = d_init > {16'd0, cfg.loop_timeout};
  assign judge_init = judge_pins(item, cfg.ramp_mode, 1'b1);
  assign judge_hb   = judge_pins(item, cfg.ramp_mode, 1'b0);

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v != CNT_MAX) ? v + 16'd1 : v;
  endfunction

  always_comb begin
    nxt     = cur;
    st      = cur.status;
    sampled = 1'b0;
    wr_set  = 1'b0;
    rst_drv = 1'b0;

    case (item.func)
      FUNC_TICK: begin
        if (is_busy(cur.status)) begin
          if (due_retry || due_beat) begin
            if (due_retry) nxt.last_check = t;
            if (due_beat)  nxt.last_beat  = t;
            st      = judge_init;
            sampled = 1'b1;
          end
          if (expired && !is_done(st)) st = expire(st);
          nxt.status = st;
          if (st != cur.status) nxt.prior = cur.status;
          if (is_ok(st)) begin
            nxt.success = sat_inc(cur.success);
            wr_set      = 1'b1;
          end
        end else if (is_err(cur.status)) begin
          // recovery: restart plus an immediate check, both cadences restart from now
          if (due_reinit) begin
            nxt.last_reinit = t;
            nxt.init_start  = t;
            nxt.last_check  = t;
            nxt.last_beat   = t;
            nxt.prior       = ST_RETRYING;
            nxt.status      = judge_init;
            sampled         = 1'b1;
            rst_drv         = 1'b1;
            if (is_ok(judge_init)) begin
              nxt.success = sat_inc(cur.success);
              wr_set      = 1'b1;
            end
          end
        end else if (is_ok(cur.status)) begin
          if (due_beat) begin
            nxt.last_beat = t;
            sampled       = 1'b1;
            if (!is_ok(judge_hb)) begin
              nxt.init_start = t;
              nxt.last_check = t - {16'd0, cfg.retry_delay};
              nxt.last_beat  = t - {16'd0, cfg.heartbeat_interval};
              nxt.status     = ST_RETRYING;
              rst_drv        = 1'b1;
            end
          end
        end
      end
      FUNC_START: begin
        if (cur.status != ST_ESTOP) begin
          nxt.init_start = t;
          nxt.last_check = t - {16'd0, cfg.retry_delay};
          nxt.last_beat  = t - {16'd0, cfg.heartbeat_interval};
          nxt.status     = ST_RETRYING;
          rst_drv        = 1'b1;
        end
      end
      FUNC_ESTOP: begin
        nxt.status = ST_ESTOP;
      end
      FUNC_CLEAR: begin
        // always restarts; the first check runs at once and cannot time out
        nxt.last_reinit = '0;
        nxt.init_start  = t;
        nxt.last_check  = t;
        nxt.last_beat   = t;
        nxt.prior       = ST_RETRYING;
        nxt.status      = judge_init;
        sampled         = 1'b1;
        rst_drv         = 1'b1;
        if (is_ok(judge_init)) begin
          nxt.success = sat_inc(cur.success);
          wr_set      = 1'b1;
        end
      end
      default: ;
    endcase

    res.status_code    = nxt.status;
    res.prior_status   = nxt.prior;
    res.pins_sampled   = sampled;
    res.write_settings = wr_set;
    res.reset_driver   = rst_drv;
    res.success_count  = nxt.success;
  end

endmodule

// File: rtl/driver_init_health_supervisor.sv
// Pipeline: an accepted item sits in the input register, then moves into the
//   result register once that register is free.
// Throughput: one item per cycle while out_ready holds; the supervisor state
//   updates in the same cycle the item moves into the result register.
// Reset: synchronous, active low; status idle, all timestamps and the success
//   count zero, configuration back to its defaults.
// ----------------------------------------------------------------------------
// driver_init_health_supervisor
// Bring-up and health supervisor for a motor driver: tracks init retries,
// timeouts, heartbeat checks and recovery from errors.
// ----------------------------------------------------------------------------
module driver_init_health_supervisor
  import dihs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // command items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  state_t    state_r, state_nxt;
  out_item_t res;

  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;

  logic      advance;
  logic      fire;

  // The result register frees up when empty or when its item is taken;
  // the input register then drains into it in the same cycle.
  assign advance  = !out_vld_r || out_ready;
  assign fire     = s1_vld_r && advance;
  assign in_ready = !s1_vld_r || advance;

  dihs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dihs_step u_step (
    .item (s1_item_r),
    .cfg  (cfg),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // control and supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r            <= 1'b0;
      out_vld_r           <= 1'b0;
      state_r.status      <= ST_IDLE;
      state_r.prior       <= ST_IDLE;
      state_r.init_start  <= '0;
      state_r.last_check  <= '0;
      state_r.last_beat   <= '0;
      state_r.last_reinit <= '0;
      state_r.success     <= '0;
    end else begin
      if (in_ready) s1_vld_r  <= in_valid;
      if (advance)  out_vld_r <= s1_vld_r;
      if (fire)     state_r   <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r  <= in_data;
    if (fire)                 out_item_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
